// File: rtl/clock_relative_gate_generator_top_defines.svh
// Assertion macros shared by the gate generator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CLOCK_RELATIVE_GATE_GENERATOR_TOP_DEFINES_SVH
`define CLOCK_RELATIVE_GATE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CRGG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRGG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/crgg_pkg.sv
// Shared constants and types of the clock-relative gate generator.
// No dependencies; used by the top level and by its checker.
package crgg_pkg;

  localparam int TICK_WIDTH_DEF = 24;
  localparam int MAX_RATIO_DEF  = 64;

  // Progress through the divided period is always a 32-bit saturating count.
  localparam int PROG_W        = 32;
  localparam int FRAC_W        = 17;
  localparam int RATIO_IN_W    = 7;
  localparam int CFG_INIT_W    = 24;
  localparam int CFG_MINGATE_W = 16;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 24;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 8;

  localparam logic [FRAC_W-1:0]        FRAC_ONE        = 17'h10000;
  localparam logic [CFG_INIT_W-1:0]    INIT_PERIOD_RST = 24'd24000;
  localparam logic [CFG_MINGATE_W-1:0] MIN_GATE_RST    = 16'd48;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RST_SCOPE   = 2'd0,
    REG_INIT_PERIOD = 2'd1,
    REG_MIN_GATE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_MOD,
    ST_DONE
  } crgg_state_t;

endpackage

// File: rtl/clock_relative_gate_generator_top.sv
// Clock-relative gate generator: measures a clock period in sample ticks and
// derives divided/multiplied gates. Depends on crgg_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one word per sample tick. m_tvalid/m_tready/
//   m_tdata return one gate word per accepted input word, in order.
//   cfg_valid/cfg_addr/cfg_data write the three registers; cfg_ready is
//   always high. Write them only while no input word is in flight.
// Sequence:
//   Each word is worked on bit-serially by shift units in turn: period *
//   divide_by, then the restoring division by multiply_by, then the progress
//   modulo (the gate-length product runs alongside its last FRAC_W steps),
//   then the decide step, which waits while the output register is full.
//   RW = clog2(MAX_RATIO + 1). m_tvalid rises as the decided word is handed
//   out, and the next word can be accepted in that same cycle; no word is
//   taken while one is in work.
// Reset:
//   rst (synchronous, active high) restores the register defaults, forgets
//   any seen clock, loads the initial period and empties the output stage.
// Stall:
//   A finished gate word waits in the output register while a new input is
//   taken; a second result waits in the decide step until m_tready frees it.
module clock_relative_gate_generator_top #(
  parameter int TICK_WIDTH = crgg_pkg::TICK_WIDTH_DEF,
  parameter int MAX_RATIO  = crgg_pkg::MAX_RATIO_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata, lowest bit up: clock_edge[0], clock_connected[1], reset_edge[2],
  // divide_by[9:3], multiply_by[16:10], gate_fraction[33:17], zeros[39:34]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [crgg_pkg::S_TDATA_W-1:0]     s_tdata,
  // m_tdata, lowest bit up: gate[0], zeros[7:1]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [crgg_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crgg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [crgg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import crgg_pkg::*;

  localparam int TW    = TICK_WIDTH;
  localparam int RW    = $clog2(MAX_RATIO + 1);
  localparam int DW    = TW + RW;
  localparam int CW    = (DW > PROG_W) ? DW : PROG_W;
  localparam int EW    = (TW > CFG_INIT_W) ? TW : CFG_INIT_W;
  localparam int RXW   = (RW > RATIO_IN_W) ? RW : RATIO_IN_W;
  localparam int CNT_W = $clog2(CW);

  localparam logic [TW-1:0]     TICK_MAX = {TW{1'b1}};
  localparam logic [PROG_W-1:0] PROG_MAX = {PROG_W{1'b1}};
  localparam logic [EW-1:0]     INIT_RST_EXT = EW'(INIT_PERIOD_RST);
  localparam logic [TW-1:0]     PERIOD_RST =
    (INIT_RST_EXT > EW'(TICK_MAX)) ? TICK_MAX : INIT_RST_EXT[TW-1:0];

  function automatic logic [RW-1:0] clamp_ratio(input logic [RATIO_IN_W-1:0] v);
    logic [RXW-1:0] w;
    w = RXW'(v);
    if (w == '0) return RW'(1);
    if (w > RXW'(MAX_RATIO)) return RW'(MAX_RATIO);
    return w[RW-1:0];
  endfunction

  // Configuration registers.
  logic                     rst_scope;
  logic [CFG_INIT_W-1:0]    init_period;
  logic [CFG_MINGATE_W-1:0] min_gate;

  // Block state.
  logic              since_valid;
  logic [TW-1:0]     ticks;
  logic [TW-1:0]     period;
  logic [RW-1:0]     dcnt;
  logic [PROG_W-1:0] prog;

  logic              since_valid_next;
  logic [TW-1:0]     ticks_next;
  logic [TW-1:0]     period_next;
  logic [RW-1:0]     dcnt_next;
  logic [PROG_W-1:0] prog_next;
  logic              active_next;

  // Serial datapath.
  crgg_state_t       state;
  crgg_state_t       state_next;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic [RW-1:0]     mul_r;
  logic [DW-1:0]     mcand;
  logic [RW-1:0]     mplier;
  logic [DW-1:0]     acc;
  logic [DW-1:0]     divided;
  logic [DW-1:0]     q;
  logic [RW-1:0]     rem;
  logic [PROG_W-1:0] pq;
  logic [DW-1:0]     mrem;
  logic [DW-1:0]     hi;
  logic [FRAC_W-1:0] lo;
  logic              gate_q;

  logic              in_accept;
  logic              out_load;
  logic              in_clk;
  logic              in_conn;
  logic              in_rst;
  logic [RW-1:0]     div_c;
  logic [RW-1:0]     mul_c;
  logic [FRAC_W-1:0] frac_in;
  logic [FRAC_W-1:0] frac_c;
  logic [EW-1:0]     init_ext;
  logic [TW-1:0]     init_sat;

  logic [DW-1:0]     acc_next;
  logic [RW:0]       rem_sh;
  logic              rem_ge;
  logic [RW:0]       rem_diff;
  logic [DW:0]       msh;
  logic              m_ge;
  logic [DW:0]       m_diff;
  logic [DW:0]       fsum;
  logic [DW-1:0]     glen;
  logic [DW-1:0]     glen_eff;
  logic [DW-1:0]     phase;
  logic              prog_in_range;
  logic              gate_c;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(M_TDATA_W-1){1'b0}}, gate_q};

  assign in_clk  = s_tdata[0];
  assign in_conn = s_tdata[1];
  assign in_rst  = s_tdata[2];
  assign div_c   = clamp_ratio(s_tdata[9:3]);
  assign mul_c   = clamp_ratio(s_tdata[16:10]);
  assign frac_in = s_tdata[33:17];
  assign frac_c  = (frac_in > FRAC_ONE) ? FRAC_ONE : frac_in;

  assign init_ext = EW'(init_period);
  assign init_sat = (init_ext > EW'(TICK_MAX)) ? TICK_MAX : init_ext[TW-1:0];

  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rst_scope   <= 1'b0;
      init_period <= INIT_PERIOD_RST;
      min_gate    <= MIN_GATE_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RST_SCOPE:   rst_scope   <= cfg_data[0];
        REG_INIT_PERIOD: init_period <= cfg_data[CFG_INIT_W-1:0];
        REG_MIN_GATE:    min_gate    <= cfg_data[CFG_MINGATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-tick state update: reset edge first, then the clock logic.
  always_comb begin
    since_valid_next = since_valid;
    ticks_next       = ticks;
    period_next      = period;
    dcnt_next        = dcnt;
    prog_next        = prog;
    if (in_rst) begin
      if (!rst_scope) begin
        since_valid_next = 1'b0;
        period_next      = init_sat;
      end
      dcnt_next = '0;
      prog_next = '0;
    end
    if (in_conn) begin
      if (in_clk) begin
        if (since_valid_next && (ticks_next != '0)) period_next = ticks_next;
        since_valid_next = 1'b1;
        ticks_next       = '0;
      end
      if (since_valid_next) begin
        if (ticks_next != TICK_MAX) ticks_next = ticks_next + TW'(1);
        if (in_clk) begin
          if (dcnt_next == '0) begin
            prog_next = '0;
          end else if (prog_next != PROG_MAX) begin
            prog_next = prog_next + PROG_W'(1);
          end
          dcnt_next = dcnt_next + RW'(1);
          if (dcnt_next >= div_c) dcnt_next = '0;
        end else if (prog_next != PROG_MAX) begin
          prog_next = prog_next + PROG_W'(1);
        end
      end
    end
    active_next = in_conn && since_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_valid <= 1'b0;
      ticks       <= '0;
      period      <= PERIOD_RST;
      dcnt        <= '0;
      prog        <= '0;
    end else if (in_accept) begin
      since_valid <= since_valid_next;
      ticks       <= ticks_next;
      period      <= period_next;
      dcnt        <= dcnt_next;
      prog        <= prog_next;
    end
  end

  // One step of each serial unit.
  assign acc_next = acc + (mplier[0] ? mcand : DW'(0));

  assign rem_sh   = {rem, q[DW-1]};
  assign rem_ge   = rem_sh >= {1'b0, mul_r};
  assign rem_diff = rem_sh - {1'b0, mul_r};

  assign msh    = {mrem, pq[PROG_W-1]};
  assign m_ge   = msh >= {1'b0, q};
  assign m_diff = msh - {1'b0, q};

  assign fsum = {1'b0, hi} + (lo[0] ? {1'b0, q} : (DW + 1)'(0));

  // Decision: product of sub-period and fraction, shifted down by 16, is {hi, lo msb}.
  assign glen     = {hi[DW-2:0], lo[FRAC_W-1]};
  assign glen_eff = (glen < DW'(min_gate)) ? DW'(min_gate) : glen;
  assign phase    = (q == '0) ? '0 : mrem;
  assign prog_in_range = CW'(prog) < CW'(divided);
  assign gate_c   = active && prog_in_range && (phase <= glen_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == '0) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          active <= active_next;
          mul_r  <= mul_c;
          mcand  <= DW'(period_next);
          mplier <= div_c;
          acc    <= '0;
          lo     <= frac_c;
          cnt    <= CNT_W'(RW - 1);
        end
      end
      ST_MUL: begin
        acc    <= acc_next;
        mcand  <= {mcand[DW-2:0], 1'b0};
        mplier <= {1'b0, mplier[RW-1:1]};
        cnt    <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          divided <= acc_next;
          q       <= acc_next;
          rem     <= '0;
          cnt     <= CNT_W'(DW - 1);
        end
      end
      ST_DIV: begin
        rem <= rem_ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
        q   <= {q[DW-2:0], rem_ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          pq   <= prog;
          mrem <= '0;
          hi   <= '0;
          cnt  <= CNT_W'(PROG_W - 1);
        end
      end
      ST_MOD: begin
        mrem <= m_ge ? m_diff[DW-1:0] : msh[DW-1:0];
        pq   <= {pq[PROG_W-2:0], 1'b0};
        // The gate-length product uses the last FRAC_W steps of the modulo.
        if (cnt < CNT_W'(FRAC_W)) begin
          hi <= fsum[DW:1];
          lo <= {fsum[0], lo[FRAC_W-1:1]};
        end
        cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) gate_q <= gate_c;
  end

endmodule

// File: rtl/crgg_checker.sv
// Port-level checker for the clock-relative gate generator, bound to the top.
// Depends on crgg_pkg and clock_relative_gate_generator_top_defines.svh.
`include "clock_relative_gate_generator_top_defines.svh"

module crgg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [crgg_pkg::M_TDATA_W-1:0] m_tdata
);
  import crgg_pkg::*;

  // Words accepted at the input and not yet delivered at the output.
  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  `CRGG_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `CRGG_ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid,
                    m_tdata[M_TDATA_W-1:1] == '0, "output padding bits not zero")
  `CRGG_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready,
                    !s_tready, "input taken again while a word is in work")
  `CRGG_ASSERT_IMPL(a_no_extra_word, clk, rst, m_tvalid,
                    pend != 2'd0, "output word without an accepted input")
  `CRGG_ASSERT_IMPL(a_bounded_backlog, clk, rst, s_tvalid && s_tready,
                    pend <= 2'd1, "more than one finished word waiting")

endmodule

bind clock_relative_gate_generator_top crgg_checker u_crgg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
// Self-checking testbench for the clock-relative gate generator top level.
// Depends on crgg_pkg and clock_relative_gate_generator_top; predicts every gate word itself.
// Directed probes come first, then random clock patterns under several register settings.
module testbench;
  import crgg_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 220;
  localparam logic [TICK_WIDTH_DEF-1:0] TICK_ALL = '1;
  localparam logic [PROG_W-1:0]         PROG_ALL = '1;

  // How a directed row gets its expected gate.
  typedef enum logic [1:0] {
    BY_MODEL,
    GATE_LOW,
    GATE_HIGH
  } probe_chk_t;

  typedef struct packed {
    logic                  ce;
    logic                  cc;
    logic                  re;
    logic [RATIO_IN_W-1:0] div;
    logic [RATIO_IN_W-1:0] mul;
    logic [FRAC_W-1:0]     frac;
    probe_chk_t            chk;
  } probe_row_t;

  // Fields: clock edge, connected, reset edge, divide, multiply, fraction, expectation.
  localparam probe_row_t PROBES [16] = '{
    '{1'b0, 1'b0, 1'b0, 7'd0,   7'd0,   17'd0,      GATE_LOW},  // no source
    '{1'b1, 1'b0, 1'b1, 7'd127, 7'd127, 17'd131071, GATE_LOW},  // no source, reset applies
    '{1'b0, 1'b1, 1'b0, 7'd64,  7'd64,  17'd65536,  GATE_LOW},  // no clock seen yet
    '{1'b1, 1'b1, 1'b0, 7'd1,   7'd1,   17'd0,      GATE_HIGH}, // first edge opens a gate
    '{1'b0, 1'b1, 1'b0, 7'd1,   7'd1,   17'd65535,  BY_MODEL},
    '{1'b1, 1'b1, 1'b0, 7'd1,   7'd64,  17'd0,      BY_MODEL},  // sub-period falls to zero
    '{1'b1, 1'b1, 1'b0, 7'd1,   7'd64,  17'd1,      BY_MODEL},
    '{1'b1, 1'b1, 1'b0, 7'd0,   7'd127, 17'd65537,  BY_MODEL},  // ratios and fraction clamp
    '{1'b0, 1'b1, 1'b0, 7'd65,  7'd0,   17'd131071, BY_MODEL},
    '{1'b0, 1'b1, 1'b0, 7'd2,   7'd3,   17'd32768,  BY_MODEL},
    '{1'b1, 1'b1, 1'b0, 7'd2,   7'd2,   17'd32768,  BY_MODEL},
    '{1'b0, 1'b0, 1'b0, 7'd2,   7'd2,   17'd32768,  GATE_LOW},
    '{1'b0, 1'b1, 1'b1, 7'd3,   7'd1,   17'd1,      GATE_LOW},  // hard reset forgets the clock
    '{1'b1, 1'b1, 1'b1, 7'd64,  7'd1,   17'd65536,  BY_MODEL},  // reset and edge together
    '{1'b0, 1'b1, 1'b0, 7'd64,  7'd1,   17'd65536,  BY_MODEL},
    '{1'b0, 1'b1, 1'b0, 7'd64,  7'd2,   17'd85,     BY_MODEL}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_addr  = REG_RST_SCOPE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register copies and block state as the predictor sees them.
  logic                      p_mode   = 1'b0;
  logic [CFG_INIT_W-1:0]     p_init   = INIT_PERIOD_RST;
  logic [CFG_MINGATE_W-1:0]  p_min    = MIN_GATE_RST;
  logic                      seen     = 1'b0;
  logic [TICK_WIDTH_DEF-1:0] ticks    = '0;
  logic [TICK_WIDTH_DEF-1:0] period   = INIT_PERIOD_RST;
  logic [RATIO_IN_W-1:0]     divcnt   = '0;
  logic [PROG_W-1:0]         progress = '0;

  logic predicted_gates [$];
  int   errors         = 0;
  int   words_sent     = 0;
  int   gates_checked  = 0;
  int   gates_high     = 0;
  int   settings_count = 1;
  int   idle_cycles    = 0;
  int   ready_hold     = 0;
  logic calm           = 1'b0;

  clock_relative_gate_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // clock_edge, clock_connected, reset_edge, divide_by, multiply_by, gate_fraction
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // gate
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [S_TDATA_W-1:0] pack_word(input logic ce, input logic cc,
      input logic re, input logic [RATIO_IN_W-1:0] d, input logic [RATIO_IN_W-1:0] m,
      input logic [FRAC_W-1:0] f);
    return {6'b0, f, m, d, re, cc, ce};
  endfunction

  // Advances the predicted block state by one sample tick and returns its gate.
  function automatic logic next_gate(input logic [S_TDATA_W-1:0] w);
    logic        ce, cc, re, g;
    logic [63:0] d, m, f, divided, sub, glen, ph;
    ce = w[0];
    cc = w[1];
    re = w[2];
    d  = 64'(w[9:3]);
    m  = 64'(w[16:10]);
    f  = 64'(w[33:17]);
    g  = 1'b0;
    if (d < 64'd1) d = 64'd1;
    else if (d > 64'(MAX_RATIO_DEF)) d = 64'(MAX_RATIO_DEF);
    if (m < 64'd1) m = 64'd1;
    else if (m > 64'(MAX_RATIO_DEF)) m = 64'(MAX_RATIO_DEF);
    if (f > 64'(FRAC_ONE)) f = 64'(FRAC_ONE);

    if (re) begin
      if (!p_mode) begin
        seen   = 1'b0;
        period = p_init;
      end
      divcnt   = '0;
      progress = '0;
    end

    if (cc) begin
      if (ce) begin
        if (seen && ticks != 0) period = ticks;
        seen  = 1'b1;
        ticks = '0;
      end
      if (seen) begin
        if (ticks != TICK_ALL) ticks = ticks + TICK_WIDTH_DEF'(1);
        divided = 64'(period) * d;
        sub     = divided / m;
        glen    = (sub * f) >> 16;
        if (glen < 64'(p_min)) glen = 64'(p_min);

        if (ce) begin
          // The divider restarts the progress count on its first clock of a period.
          if (divcnt == 0) progress = '0;
          else if (progress != PROG_ALL) progress = progress + PROG_W'(1);
          divcnt = divcnt + RATIO_IN_W'(1);
          if (64'(divcnt) >= d) divcnt = '0;
        end else if (progress != PROG_ALL) begin
          progress = progress + PROG_W'(1);
        end

        if (64'(progress) < divided) begin
          ph = (sub == 0) ? 64'd0 : 64'(progress) % sub;
          g  = (ph <= glen);
        end
      end
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 160);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_word(input logic [S_TDATA_W-1:0] w, input probe_chk_t chk);
    int   gap;
    logic g;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = next_gate(w);
    case (chk)
      GATE_LOW:  predicted_gates.push_back(1'b0);
      GATE_HIGH: predicted_gates.push_back(1'b1);
      default:   predicted_gates.push_back(g);
    endcase
    words_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RST_SCOPE:   p_mode = val[0];
      REG_INIT_PERIOD: p_init = val[CFG_INIT_W-1:0];
      REG_MIN_GATE:    p_min  = val[CFG_MINGATE_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only once every gate word has come back.
  task automatic new_settings(input logic [CFG_DATA_W-1:0] mode_word,
      input logic [CFG_DATA_W-1:0] init_word, input logic [CFG_DATA_W-1:0] min_word);
    while (predicted_gates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_RST_SCOPE, mode_word);
    write_reg(REG_INIT_PERIOD, init_word);
    write_reg(REG_MIN_GATE, min_word);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Mostly a steady clock with held knobs, broken now and then by dropouts,
  // reset edges and words of pure noise.
  task automatic run_random(input int count);
    int                    left, per, ph, r;
    logic [RATIO_IN_W-1:0] d, m;
    logic [FRAC_W-1:0]     f;
    logic                  ce, cc, re;
    left = 0;
    per  = 1;
    ph   = 0;
    d    = 7'd1;
    m    = 7'd1;
    f    = '0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(20, 120);
        r    = $urandom_range(0, 99);
        // A period of zero stops the clock so progress runs past the divided period.
        per  = (r < 10) ? 0 : (r < 55) ? $urandom_range(1, 12) :
               (r < 88) ? $urandom_range(13, 60) : $urandom_range(61, 300);
        d = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 8));
        m = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 8));
        f = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 131071)) :
            17'($urandom_range(0, 65536));
      end
      left--;
      if ($urandom_range(0, 99) < 8) begin
        send_word(pack_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 17'($urandom_range(0, 131071))),
                  BY_MODEL);
      end else begin
        ce = 1'b0;
        if (per != 0) begin
          ph++;
          if (ph >= per) begin
            ph = 0;
            ce = 1'b1;
          end
        end
        cc = ($urandom_range(0, 99) >= 3);
        re = ($urandom_range(0, 199) < 3);
        send_word(pack_word(ce, cc, re, d, m, f), BY_MODEL);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_gates.size() == 0) begin
        report_mismatch($sformatf("gate word %0b arrived with none expected", m_tdata[0]));
      end else begin
        if (m_tdata[0] !== predicted_gates[0])
          report_mismatch($sformatf("gate word %0d: got %0b, expected %0b",
                                    gates_checked, m_tdata[0], predicted_gates[0]));
        void'(predicted_gates.pop_front());
      end
      gates_checked++;
      if (m_tdata[0] === 1'b1) gates_high++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: %0d cycles without a handshake", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The directed probes go first, then the random part takes over the input channel.
    for (int k = 0; k < $size(PROBES); k++)
      send_word(pack_word(PROBES[k].ce, PROBES[k].cc, PROBES[k].re, PROBES[k].div,
                          PROBES[k].mul, PROBES[k].frac), PROBES[k].chk);
    run_random(RANDOM_ITEMS);

    // Soft reset, zero initial period and zero minimum gate.
    new_settings(24'd1, 24'd0, 24'd0);
    run_random(RANDOM_ITEMS);

    // Largest period and gate, with both sides running flat out.
    calm = 1'b1;
    new_settings(24'd0, 24'hFFFFFF, 24'h00FFFF);
    run_random(RANDOM_ITEMS);
    calm = 1'b0;

    // Hard resets land on a zero period.
    new_settings(24'd0, 24'd0, 24'd1);
    run_random(RANDOM_ITEMS);

    // Unused upper data bits set to random values.
    new_settings({23'($urandom), 1'b1}, 24'($urandom), 24'($urandom));
    run_random(RANDOM_ITEMS);

    new_settings(24'd0, 24'($urandom_range(1, 2000)), 24'($urandom_range(1, 8)));
    run_random(RANDOM_ITEMS);

    while (predicted_gates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d sample words under %0d register settings.", words_sent, settings_count);
    $display("Checked %0d gate words, %0d of them high.", gates_checked, gates_high);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: clock_relative_gate_generator_top.f
+incdir+rtl
rtl/crgg_pkg.sv
rtl/clock_relative_gate_generator_top.sv
rtl/crgg_checker.sv
tb/testbench.sv
